### sv/legged_body_balance_loop_defines.svh
// Assertion macros for the legged body balance loop.
// Needs signals named clk and rst_n in the including module.
`ifndef LEGGED_BODY_BALANCE_LOOP_DEFINES_SVH
`define LEGGED_BODY_BALANCE_LOOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LBB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LBB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/lbb_pkg.sv
// Shared widths, types, register codes and arithmetic helpers for the
// body balance loop. No dependencies.
package lbb_pkg;

  localparam int FORCE_W    = 16;
  localparam int ANGLE_W    = 16;
  localparam int STEP_W     = 16;
  localparam int SHIFT_W    = 24;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 23;
  localparam int TILT_W     = 15;
  localparam int DIFF_W     = FORCE_W + 2;
  localparam int GDT_W      = GAIN_W + STEP_W;
  localparam int MUL_A_W    = GDT_W + 2;
  localparam int MUL_B_W    = DIFF_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int SUM_W      = SHIFT_W + 4;
  localparam int TGT_W      = ANGLE_W + 8;
  localparam int EMA_DIFF_W = ANGLE_W + 1;
  localparam int EMA_SUM_W  = ANGLE_W + 2;

  localparam int INC_SHIFT  = 24;
  localparam int TILT_SHIFT = 12;
  localparam int EMA_SHIFT  = 16;
  localparam logic signed [MUL_B_W-1:0] EMA_WEIGHT = 18'sd13107;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LIMIT_W;

  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_LIMIT = 3'd4;

  localparam logic [GAIN_W-1:0]  RST_SHIFT_GAIN  = 16'd256;
  localparam logic [LIMIT_W-1:0] RST_SHIFT_LIMIT = 23'd5120;
  localparam logic [GAIN_W-1:0]  RST_PITCH_GAIN  = 16'd4096;
  localparam logic [GAIN_W-1:0]  RST_ROLL_GAIN   = 16'd4096;
  localparam logic [TILT_W-1:0]  RST_TILT_LIMIT  = 15'd715;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef struct packed {
    logic [GAIN_W-1:0]  shift_gain;
    logic [LIMIT_W-1:0] shift_limit;
    logic [GAIN_W-1:0]  pitch_gain;
    logic [GAIN_W-1:0]  roll_gain;
    logic [TILT_W-1:0]  tilt_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dz;
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] roll;
    logic [STEP_W-1:0]         dt;
  } item_t;

  // Integrate one increment (product floored by 2^24) and clamp to +/- limit.
  function automatic logic signed [SHIFT_W-1:0] integ_step(
    input logic signed [SHIFT_W-1:0] acc,
    input logic signed [PROD_W-1:0]  prod,
    input logic [LIMIT_W-1:0]        limit
  );
    logic signed [SUM_W-1:0]   inc;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   lim;
    logic signed [SHIFT_W-1:0] res;
    inc = SUM_W'(prod >>> INC_SHIFT);
    sum = SUM_W'(acc) + inc;
    lim = SUM_W'({1'b0, limit});
    if (sum > lim) begin
      res = SHIFT_W'(lim);
    end else if (sum < -lim) begin
      res = SHIFT_W'(-lim);
    end else begin
      res = SHIFT_W'(sum);
    end
    return res;
  endfunction

  // Negated proportional tilt, floored by 2^12 and clamped to +/- limit.
  function automatic logic signed [ANGLE_W-1:0] tilt_target(
    input logic signed [PROD_W-1:0] prod,
    input logic [TILT_W-1:0]        limit
  );
    logic signed [PROD_W-1:0]  neg;
    logic signed [TGT_W-1:0]   sh;
    logic signed [TGT_W-1:0]   lim;
    logic signed [ANGLE_W-1:0] res;
    neg = -prod;
    sh  = TGT_W'(neg >>> TILT_SHIFT);
    lim = TGT_W'({1'b0, limit});
    if (sh > lim) begin
      res = ANGLE_W'(lim);
    end else if (sh < -lim) begin
      res = ANGLE_W'(-lim);
    end else begin
      res = ANGLE_W'(sh);
    end
    return res;
  endfunction

  // Exponential average step: s + floor(prod / 2^16).
  function automatic logic signed [ANGLE_W-1:0] ema_step(
    input logic signed [ANGLE_W-1:0] s,
    input logic signed [PROD_W-1:0]  prod
  );
    logic signed [EMA_SUM_W-1:0] step;
    logic signed [EMA_SUM_W-1:0] sum;
    step = EMA_SUM_W'(prod >>> EMA_SHIFT);
    sum  = EMA_SUM_W'(s) + step;
    return ANGLE_W'(sum);
  endfunction

endpackage

### sv/lbb_front.sv
// Front end: accepts input transfers and forms the fore-aft and lateral
// load imbalances. Depends on lbb_pkg; feeds lbb_fifo.
module lbb_front (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lbb_pkg::FORCE_W-1:0]  in_force_front_left,
  input  logic [lbb_pkg::FORCE_W-1:0]  in_force_front_right,
  input  logic [lbb_pkg::FORCE_W-1:0]  in_force_rear_right,
  input  logic [lbb_pkg::FORCE_W-1:0]  in_force_rear_left,
  input  logic signed [lbb_pkg::ANGLE_W-1:0] in_measured_pitch,
  input  logic signed [lbb_pkg::ANGLE_W-1:0] in_measured_roll,
  input  logic [lbb_pkg::STEP_W-1:0]   in_time_step,
  input  logic                         fifo_full,
  output logic                         push,
  output lbb_pkg::item_t               push_data
);
  import lbb_pkg::*;

  logic [FORCE_W:0] rear_sum;
  logic [FORCE_W:0] front_sum;
  logic [FORCE_W:0] left_sum;
  logic [FORCE_W:0] right_sum;

  assign rear_sum  = {1'b0, in_force_rear_right} + {1'b0, in_force_rear_left};
  assign front_sum = {1'b0, in_force_front_left} + {1'b0, in_force_front_right};
  assign left_sum  = {1'b0, in_force_front_left} + {1'b0, in_force_rear_left};
  assign right_sum = {1'b0, in_force_front_right} + {1'b0, in_force_rear_right};

  assign in_stall = fifo_full;
  assign push     = in_valid && !fifo_full;

  always_comb begin
    push_data.dx    = $signed({1'b0, rear_sum}) - $signed({1'b0, front_sum});
    push_data.dz    = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});
    push_data.pitch = in_measured_pitch;
    push_data.roll  = in_measured_roll;
    push_data.dt    = in_time_step;
  end

endmodule

### sv/lbb_fifo.sv
// Short queue of classified items between front and back end.
// Depends on lbb_pkg and the assertion macro header.
`include "legged_body_balance_loop_defines.svh"

module lbb_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lbb_pkg::item_t wdata,
  input  logic           pop,
  output lbb_pkg::item_t rdata,
  output logic           full,
  output logic           empty
);
  import lbb_pkg::*;

  item_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r;
  logic [FIFO_CNT_W-1:0] count_nxt;

  assign full  = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `LBB_ASSERT_NOW(a_no_underflow, pop, count_r != '0, "pop from empty queue")
  `LBB_ASSERT_NOW(a_no_overflow, push && !pop, count_r != FIFO_CNT_W'(FIFO_DEPTH), "push into full queue")

endmodule

### sv/lbb_back.sv
// Back end: sequences one shared multiplier through the eight steps of an
// item and holds the integrator and smoother state. Depends on lbb_pkg.
`include "legged_body_balance_loop_defines.svh"

module lbb_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lbb_pkg::cfg_t                     cfg,
  input  logic                              fifo_empty,
  input  lbb_pkg::item_t                    fifo_rdata,
  output logic                              fifo_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lbb_pkg::SHIFT_W-1:0] out_shift_fore_aft,
  output logic signed [lbb_pkg::SHIFT_W-1:0] out_shift_lateral,
  output logic signed [lbb_pkg::ANGLE_W-1:0] out_pitch_command,
  output logic signed [lbb_pkg::ANGLE_W-1:0] out_roll_command
);
  import lbb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GDT, ST_PITCH, ST_ROLL, ST_FA, ST_LAT, ST_EMAP, ST_EMAR, ST_WB
  } state_t;

  state_t                     state_r;
  state_t                     state_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic                       slot_free;
  logic                       wb_done;

  item_t                      item_r;
  logic [GDT_W-1:0]           gdt_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [ANGLE_W-1:0]  tgt_p_r;
  logic signed [ANGLE_W-1:0]  tgt_r_r;

  logic signed [SHIFT_W-1:0]  fa_r;
  logic signed [SHIFT_W-1:0]  lat_r;
  logic signed [ANGLE_W-1:0]  pitch_s_r;
  logic signed [ANGLE_W-1:0]  roll_s_r;
  logic signed [ANGLE_W-1:0]  roll_s_nxt;

  logic signed [SHIFT_W-1:0]  out_fa_r;
  logic signed [SHIFT_W-1:0]  out_lat_r;
  logic signed [ANGLE_W-1:0]  out_pitch_r;
  logic signed [ANGLE_W-1:0]  out_roll_r;

  logic signed [MUL_A_W-1:0]    mul_a;
  logic signed [MUL_B_W-1:0]    mul_b;
  logic signed [EMA_DIFF_W-1:0] ema_diff_p;
  logic signed [EMA_DIFF_W-1:0] ema_diff_r;

  assign slot_free  = !out_valid_r || !out_stall;
  assign wb_done    = (state_r == ST_WB) && slot_free;
  assign fifo_pop   = !fifo_empty && ((state_r == ST_IDLE) || wb_done);
  assign roll_s_nxt = ema_step(roll_s_r, prod_r);

  assign ema_diff_p = EMA_DIFF_W'(tgt_p_r) - EMA_DIFF_W'(pitch_s_r);
  assign ema_diff_r = EMA_DIFF_W'(tgt_r_r) - EMA_DIFF_W'(roll_s_r);

  // Operand select for the shared multiplier; the product lands in prod_r
  // and is consumed in the following step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_GDT: begin
        mul_a = MUL_A_W'(cfg.shift_gain);
        mul_b = MUL_B_W'(item_r.dt);
      end
      ST_PITCH: begin
        mul_a = MUL_A_W'(cfg.pitch_gain);
        mul_b = MUL_B_W'(item_r.pitch);
      end
      ST_ROLL: begin
        mul_a = MUL_A_W'(cfg.roll_gain);
        mul_b = MUL_B_W'(item_r.roll);
      end
      ST_FA: begin
        mul_a = MUL_A_W'(gdt_r);
        mul_b = MUL_B_W'(item_r.dx);
      end
      ST_LAT: begin
        mul_a = MUL_A_W'(gdt_r);
        mul_b = MUL_B_W'(item_r.dz);
      end
      ST_EMAP: begin
        mul_a = MUL_A_W'(ema_diff_p);
        mul_b = EMA_WEIGHT;
      end
      ST_EMAR: begin
        mul_a = MUL_A_W'(ema_diff_r);
        mul_b = EMA_WEIGHT;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  state_nxt = fifo_empty ? ST_IDLE : ST_GDT;
      ST_GDT:   state_nxt = ST_PITCH;
      ST_PITCH: state_nxt = ST_ROLL;
      ST_ROLL:  state_nxt = ST_FA;
      ST_FA:    state_nxt = ST_LAT;
      ST_LAT:   state_nxt = ST_EMAP;
      ST_EMAP:  state_nxt = ST_EMAR;
      ST_EMAR:  state_nxt = ST_WB;
      ST_WB: begin
        if (slot_free) begin
          state_nxt = fifo_empty ? ST_IDLE : ST_GDT;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (wb_done) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      fa_r        <= '0;
      lat_r       <= '0;
      pitch_s_r   <= '0;
      roll_s_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_LAT) begin
        fa_r <= integ_step(fa_r, prod_r, cfg.shift_limit);
      end
      if (state_r == ST_EMAP) begin
        lat_r <= integ_step(lat_r, prod_r, cfg.shift_limit);
      end
      if (state_r == ST_EMAR) begin
        pitch_s_r <= ema_step(pitch_s_r, prod_r);
      end
      if (wb_done) begin
        roll_s_r    <= roll_s_nxt;
        out_fa_r    <= fa_r;
        out_lat_r   <= lat_r;
        out_pitch_r <= pitch_s_r;
        out_roll_r  <= roll_s_nxt;
      end
    end
  end

  // Working registers; hold the product while waiting to write back.
  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      item_r <= fifo_rdata;
    end
    if (state_r != ST_WB) begin
      prod_r <= prod_nxt;
    end
    if (state_r == ST_PITCH) begin
      gdt_r <= prod_r[GDT_W-1:0];
    end
    if (state_r == ST_ROLL) begin
      tgt_p_r <= tilt_target(prod_r, cfg.tilt_limit);
    end
    if (state_r == ST_FA) begin
      tgt_r_r <= tilt_target(prod_r, cfg.tilt_limit);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_shift_fore_aft = out_fa_r;
  assign out_shift_lateral  = out_lat_r;
  assign out_pitch_command  = out_pitch_r;
  assign out_roll_command   = out_roll_r;

  `LBB_ASSERT_NOW(a_out_from_wb, $rose(out_valid_r), $past(state_r) == ST_WB, "result without write-back")
  `LBB_ASSERT_NEXT(a_seq_gdt, state_r == ST_GDT, state_r == ST_PITCH, "step sequence broken")

endmodule

### sv/legged_body_balance_loop.sv
// The back end runs each item through an eight-step sequence on the single shared
// multiplier and takes no new item until the last one is written back; a 2-entry
// queue takes inputs meanwhile.
// Reset (synchronous, active low) clears integrators, smoothers, queue and
// handshake state and loads the register defaults.
module legged_body_balance_loop (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lbb_pkg::FORCE_W-1:0]       in_force_front_left,
  input  logic [lbb_pkg::FORCE_W-1:0]       in_force_front_right,
  input  logic [lbb_pkg::FORCE_W-1:0]       in_force_rear_right,
  input  logic [lbb_pkg::FORCE_W-1:0]       in_force_rear_left,
  input  logic signed [lbb_pkg::ANGLE_W-1:0] in_measured_pitch,
  input  logic signed [lbb_pkg::ANGLE_W-1:0] in_measured_roll,
  input  logic [lbb_pkg::STEP_W-1:0]        in_time_step,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lbb_pkg::SHIFT_W-1:0] out_shift_fore_aft,
  output logic signed [lbb_pkg::SHIFT_W-1:0] out_shift_lateral,
  output logic signed [lbb_pkg::ANGLE_W-1:0] out_pitch_command,
  output logic signed [lbb_pkg::ANGLE_W-1:0] out_roll_command,
  input  logic                              cfg_we,
  input  logic [lbb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lbb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import lbb_pkg::*;

  cfg_t  cfg_r;
  logic  fifo_full;
  logic  fifo_empty;
  logic  push;
  logic  pop;
  item_t push_data;
  item_t pop_data;

  // Register file; unknown indexes drop the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shift_gain  <= RST_SHIFT_GAIN;
      cfg_r.shift_limit <= RST_SHIFT_LIMIT;
      cfg_r.pitch_gain  <= RST_PITCH_GAIN;
      cfg_r.roll_gain   <= RST_ROLL_GAIN;
      cfg_r.tilt_limit  <= RST_TILT_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHIFT_GAIN:  cfg_r.shift_gain  <= cfg_wdata[GAIN_W-1:0];
        REG_SHIFT_LIMIT: cfg_r.shift_limit <= cfg_wdata[LIMIT_W-1:0];
        REG_PITCH_GAIN:  cfg_r.pitch_gain  <= cfg_wdata[GAIN_W-1:0];
        REG_ROLL_GAIN:   cfg_r.roll_gain   <= cfg_wdata[GAIN_W-1:0];
        REG_TILT_LIMIT:  cfg_r.tilt_limit  <= cfg_wdata[TILT_W-1:0];
        default: ;
      endcase
    end
  end

  lbb_front u_front (
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_force_front_left  (in_force_front_left),
    .in_force_front_right (in_force_front_right),
    .in_force_rear_right  (in_force_rear_right),
    .in_force_rear_left   (in_force_rear_left),
    .in_measured_pitch    (in_measured_pitch),
    .in_measured_roll     (in_measured_roll),
    .in_time_step         (in_time_step),
    .fifo_full            (fifo_full),
    .push                 (push),
    .push_data            (push_data)
  );

  lbb_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_data),
    .pop   (pop),
    .rdata (pop_data),
    .full  (fifo_full),
    .empty (fifo_empty)
  );

  lbb_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .fifo_empty         (fifo_empty),
    .fifo_rdata         (pop_data),
    .fifo_pop           (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_shift_fore_aft (out_shift_fore_aft),
    .out_shift_lateral  (out_shift_lateral),
    .out_pitch_command  (out_pitch_command),
    .out_roll_command   (out_roll_command)
  );

endmodule

### dv/legged_body_balance_loop_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for legged_body_balance_loop: random and directed samples,
// a cycle-accurate-free predictor of shifts and smoothed tilt commands.
// Depends on lbb_pkg and the block's RTL only.
module legged_body_balance_loop_tb;
  import lbb_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD = 240;
  localparam int PHASE_SAMPLES = 185;
  localparam int FORCE_MAX = 65535;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST = 3'd7;

  typedef enum {SET_MAX, SET_ZERO, SET_GENTLE, SET_WIDE} setting_t;

  typedef struct {
    logic [FORCE_W-1:0]        force_front_left;
    logic [FORCE_W-1:0]        force_front_right;
    logic [FORCE_W-1:0]        force_rear_right;
    logic [FORCE_W-1:0]        force_rear_left;
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] roll;
    logic [STEP_W-1:0]         step;
  } sample_t;

  typedef struct {
    logic signed [SHIFT_W-1:0] fore_aft;
    logic signed [SHIFT_W-1:0] lateral;
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] roll;
  } command_t;

  class balance_predictor;
    logic [GAIN_W-1:0]  shift_gain;
    logic [LIMIT_W-1:0] shift_limit;
    logic [GAIN_W-1:0]  pitch_gain;
    logic [GAIN_W-1:0]  roll_gain;
    logic [TILT_W-1:0]  tilt_limit;
    longint fore_aft_acc;
    longint lateral_acc;
    longint pitch_avg;
    longint roll_avg;
    command_t pending[$];
    int mismatches;

    function void reset_state();
      shift_gain   = RST_SHIFT_GAIN;
      shift_limit  = RST_SHIFT_LIMIT;
      pitch_gain   = RST_PITCH_GAIN;
      roll_gain    = RST_ROLL_GAIN;
      tilt_limit   = RST_TILT_LIMIT;
      fore_aft_acc = 0;
      lateral_acc  = 0;
      pitch_avg    = 0;
      roll_avg     = 0;
      pending.delete();
      mismatches   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SHIFT_GAIN:  shift_gain = data[GAIN_W-1:0];
        REG_SHIFT_LIMIT: shift_limit = data[LIMIT_W-1:0];
        REG_PITCH_GAIN:  pitch_gain = data[GAIN_W-1:0];
        REG_ROLL_GAIN:   roll_gain = data[GAIN_W-1:0];
        REG_TILT_LIMIT:  tilt_limit = data[TILT_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_mag(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // Arithmetic right shift on a signed longint floors toward minus infinity.
    function longint integrate(longint acc, longint imbalance, longint step);
      longint inc;
      inc = (longint'(shift_gain) * imbalance * step) >>> INC_SHIFT;
      return clamp_mag(acc + inc, longint'(shift_limit));
    endfunction

    function longint smooth(longint avg, longint tilt, longint gain);
      longint target;
      target = (-(gain * tilt)) >>> TILT_SHIFT;
      target = clamp_mag(target, longint'(tilt_limit));
      return avg + (((target - avg) * longint'(EMA_WEIGHT)) >>> EMA_SHIFT);
    endfunction

    function void absorb_sample(sample_t s);
      longint fl, fr, rr, rl, step;
      command_t c;
      fl = longint'(s.force_front_left);
      fr = longint'(s.force_front_right);
      rr = longint'(s.force_rear_right);
      rl = longint'(s.force_rear_left);
      step = longint'(s.step);
      fore_aft_acc = integrate(fore_aft_acc, (rr + rl) - (fl + fr), step);
      lateral_acc  = integrate(lateral_acc, (fl + rl) - (fr + rr), step);
      pitch_avg = smooth(pitch_avg, longint'(s.pitch), longint'(pitch_gain));
      roll_avg  = smooth(roll_avg, longint'(s.roll), longint'(roll_gain));
      c.fore_aft = fore_aft_acc[SHIFT_W-1:0];
      c.lateral  = lateral_acc[SHIFT_W-1:0];
      c.pitch    = pitch_avg[ANGLE_W-1:0];
      c.roll     = roll_avg[ANGLE_W-1:0];
      pending.push_back(c);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        mismatches++;
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_command(logic signed [SHIFT_W-1:0] fore_aft,
                                logic signed [SHIFT_W-1:0] lateral,
                                logic signed [ANGLE_W-1:0] pitch,
                                logic signed [ANGLE_W-1:0] roll);
      command_t c;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none, actual fore_aft %0d lateral %0d",
                 $time, fore_aft, lateral);
        return;
      end
      c = pending.pop_front();
      compare_field("shift_fore_aft", c.fore_aft, fore_aft);
      compare_field("shift_lateral", c.lateral, lateral);
      compare_field("pitch_command", c.pitch, pitch);
      compare_field("roll_command", c.roll, roll);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FORCE_W-1:0] in_force_front_left = '0;
  logic [FORCE_W-1:0] in_force_front_right = '0;
  logic [FORCE_W-1:0] in_force_rear_right = '0;
  logic [FORCE_W-1:0] in_force_rear_left = '0;
  logic signed [ANGLE_W-1:0] in_measured_pitch = '0;
  logic signed [ANGLE_W-1:0] in_measured_roll = '0;
  logic [STEP_W-1:0] in_time_step = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SHIFT_W-1:0] out_shift_fore_aft;
  logic signed [SHIFT_W-1:0] out_shift_lateral;
  logic signed [ANGLE_W-1:0] out_pitch_command;
  logic signed [ANGLE_W-1:0] out_roll_command;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int cycle_count = 0;
  balance_predictor predictor = new;

  legged_body_balance_loop i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAIL legged_body_balance_loop");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      predictor.check_command(out_shift_fore_aft, out_shift_lateral,
                              out_pitch_command, out_roll_command);
  end

  function automatic sample_t make_sample(int fl, int fr, int rr, int rl,
                                          int pitch, int roll, int step);
    sample_t s;
    s.force_front_left  = FORCE_W'(fl);
    s.force_front_right = FORCE_W'(fr);
    s.force_rear_right  = FORCE_W'(rr);
    s.force_rear_left   = FORCE_W'(rl);
    s.pitch = ANGLE_W'(pitch);
    s.roll  = ANGLE_W'(roll);
    s.step  = STEP_W'(step);
    return s;
  endfunction

  // Mix full-range forces with near-balanced ones so the shifts do not just sit at the limit.
  function automatic sample_t draw_sample();
    sample_t s;
    int base;
    base = $urandom_range(256, 65279);
    if ($urandom_range(0, 2) == 0) begin
      s.force_front_left  = FORCE_W'(base + int'($urandom_range(0, 511)) - 256);
      s.force_front_right = FORCE_W'(base + int'($urandom_range(0, 511)) - 256);
      s.force_rear_right  = FORCE_W'(base + int'($urandom_range(0, 511)) - 256);
      s.force_rear_left   = FORCE_W'(base + int'($urandom_range(0, 511)) - 256);
    end else begin
      s.force_front_left  = FORCE_W'($urandom());
      s.force_front_right = FORCE_W'($urandom());
      s.force_rear_right  = FORCE_W'($urandom());
      s.force_rear_left   = FORCE_W'($urandom());
    end
    if ($urandom_range(0, 1) == 1) begin
      s.pitch = ANGLE_W'($urandom());
      s.roll  = ANGLE_W'($urandom());
    end else begin
      s.pitch = ANGLE_W'(int'($urandom_range(0, 4095)) - 2048);
      s.roll  = ANGLE_W'(int'($urandom_range(0, 4095)) - 2048);
    end
    s.step = ($urandom_range(0, 1) == 1) ? STEP_W'($urandom())
                                         : STEP_W'($urandom_range(0, 255));
    return s;
  endfunction

  // Hold valid low for the gap, then offer the sample until it transfers.
  task automatic send_sample(sample_t s, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_force_front_left  <= s.force_front_left;
    in_force_front_right <= s.force_front_right;
    in_force_rear_right  <= s.force_rear_right;
    in_force_rear_left   <= s.force_rear_left;
    in_measured_pitch    <= s.pitch;
    in_measured_roll     <= s.roll;
    in_time_step         <= s.step;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predictor.absorb_sample(s);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (predictor.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Fill the bits above the register width with junk half of the time; leave cfg_we high.
  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value,
                             int width);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom());
    junk = ($urandom_range(0, 1) == 1) ? (junk << width) : '0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= junk | value;
    @(posedge clk);
    predictor.write_reg(idx, junk | value);
  endtask

  task automatic apply_setting(setting_t kind);
    logic [CFG_DATA_W-1:0] sg, sl, pg, rg, tl;
    case (kind)
      SET_MAX: begin
        sg = CFG_DATA_W'(16'hFFFF);
        sl = 23'h7FFFFF;
        pg = CFG_DATA_W'(16'hFFFF);
        rg = CFG_DATA_W'(16'hFFFF);
        tl = CFG_DATA_W'(15'h7FFF);
      end
      SET_ZERO: begin
        sg = CFG_DATA_W'($urandom_range(0, 65535));
        sl = '0;
        pg = CFG_DATA_W'($urandom_range(0, 65535));
        rg = CFG_DATA_W'($urandom_range(0, 65535));
        tl = '0;
      end
      SET_GENTLE: begin
        sg = CFG_DATA_W'($urandom_range(0, 1023));
        sl = CFG_DATA_W'($urandom_range(0, 1 << 20));
        pg = CFG_DATA_W'($urandom_range(0, 8192));
        rg = CFG_DATA_W'($urandom_range(0, 8192));
        tl = CFG_DATA_W'($urandom_range(0, 4096));
      end
      default: begin
        sg = CFG_DATA_W'($urandom_range(0, 65535));
        sl = CFG_DATA_W'($urandom_range(0, 8388607));
        pg = CFG_DATA_W'($urandom_range(0, 65535));
        rg = CFG_DATA_W'($urandom_range(0, 65535));
        tl = CFG_DATA_W'($urandom_range(0, 32767));
      end
    endcase
    program_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), '0, 0);
    program_reg(REG_SHIFT_GAIN, sg, GAIN_W);
    program_reg(REG_SHIFT_LIMIT, sl, LIMIT_W);
    program_reg(REG_PITCH_GAIN, pg, GAIN_W);
    program_reg(REG_ROLL_GAIN, rg, GAIN_W);
    program_reg(REG_TILT_LIMIT, tl, TILT_W);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stall per transfer, calm stretches, two long hold-offs.
  initial begin : result_side
    int stall_len;
    int commands_seen;
    bit eager;
    commands_seen = 0;
    eager = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (commands_seen % 64 == 0) eager = ($urandom_range(0, 2) == 0);
      stall_len = eager ? 0 : $urandom_range(0, 15);
      if (commands_seen == 150 || commands_seen == 1100) stall_len = LONG_HOLD;
      out_stall <= (stall_len != 0);
      if (stall_len != 0) begin
        repeat (stall_len) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      commands_seen++;
    end
  end

  initial begin : stimulus
    setting_t plan [10];
    int p, k, gap;
    bit eager;
    plan = '{SET_MAX, SET_GENTLE, SET_WIDE, SET_ZERO, SET_GENTLE,
             SET_MAX, SET_GENTLE, SET_WIDE, SET_GENTLE, SET_WIDE};
    predictor.reset_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default registers: field extremes and each imbalance direction.
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0), 0);
    send_sample(make_sample(FORCE_MAX, FORCE_MAX, FORCE_MAX, FORCE_MAX,
                            32767, -32768, FORCE_MAX), 0);
    send_sample(make_sample(0, 0, FORCE_MAX, FORCE_MAX, -32768, 32767, FORCE_MAX), 0);
    send_sample(make_sample(FORCE_MAX, FORCE_MAX, 0, 0, 1, -1, FORCE_MAX), 0);
    send_sample(make_sample(FORCE_MAX, 0, 0, FORCE_MAX, -1, 1, 4000), 0);
    send_sample(make_sample(0, FORCE_MAX, FORCE_MAX, 0, 715, -715, 4000), 0);
    send_sample(make_sample(1000, 1000, 1000, 1000, 2048, -2048, FORCE_MAX), 0);
    send_sample(make_sample(0, 0, 1, 0, 0, 0, 1), 0);

    // Saturate the shifts at the widest limit.
    settle();
    program_reg(REG_SHIFT_GAIN, CFG_DATA_W'(16'hFFFF), GAIN_W);
    program_reg(REG_SHIFT_LIMIT, 23'h7FFFFF, LIMIT_W);
    program_reg(REG_PITCH_GAIN, CFG_DATA_W'(16'hFFFF), GAIN_W);
    program_reg(REG_ROLL_GAIN, '0, GAIN_W);
    program_reg(REG_TILT_LIMIT, CFG_DATA_W'(15'h7FFF), TILT_W);
    cfg_we <= 1'b0;
    repeat (3) send_sample(make_sample(0, 0, FORCE_MAX, FORCE_MAX,
                                       -32768, 32767, FORCE_MAX), 0);
    send_sample(make_sample(FORCE_MAX, 0, 0, FORCE_MAX, 32767, -32768, FORCE_MAX), 0);

    // Lower the limit under the held shift; a zero step must still clamp.
    settle();
    program_reg(REG_SHIFT_LIMIT, CFG_DATA_W'(300), LIMIT_W);
    cfg_we <= 1'b0;
    send_sample(make_sample(500, 500, 500, 500, 0, 0, 0), 0);

    // Zero limits force shifts and tilt targets to zero; spare index is ignored.
    settle();
    program_reg(REG_SPARE_FIRST, 23'h7FFFFF, 0);
    program_reg(REG_SHIFT_LIMIT, '0, LIMIT_W);
    program_reg(REG_TILT_LIMIT, '0, TILT_W);
    cfg_we <= 1'b0;
    send_sample(make_sample(0, 0, FORCE_MAX, FORCE_MAX, -32768, 32767, FORCE_MAX), 0);
    send_sample(make_sample(FORCE_MAX, 0, FORCE_MAX, 0, 100, -100, 77), 0);

    for (p = 0; p < 10; p++) begin
      settle();
      apply_setting(plan[p]);
      eager = 1'b0;
      for (k = 0; k < PHASE_SAMPLES; k++) begin
        if (k % 32 == 0) eager = ($urandom_range(0, 2) == 0);
        gap = eager ? 0 : $urandom_range(0, 15);
        send_sample(draw_sample(), gap);
      end
    end
    settle();

    if (predictor.mismatches == 0 && predictor.pending.size() == 0) begin
      $display("PASS legged_body_balance_loop");
    end else begin
      $display("FAIL legged_body_balance_loop");
    end
    $finish;
  end

endmodule
